[rtl/n64xl_pkg.sv]
// ----------------------------------------------------------------------------
// n64xl_pkg
// Shared types and constants for the IPv6 to IPv4 header translation core:
// beat payloads, verdict codes, protocol numbers and ICMP type codes.
// ----------------------------------------------------------------------------
package n64xl_pkg;

    // protocol and frame constants
    localparam logic [15:0] ETHERTYPE_V6   = 16'h86DD;
    localparam logic [7:0]  NH_NONE        = 8'h3B;
    localparam logic [7:0]  NH_ICMP6       = 8'h3A;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [15:0] DF_FLAG        = 16'h4000;
    localparam logic [15:0] VER_IHL        = 16'h4500;
    localparam logic [15:0] HDR_LEN        = 16'd20;
    localparam logic [31:0] V4_SRC_RESET   = 32'h0A00_0101;

    // verdict codes
    localparam logic [1:0]  VERDICT_XLATE  = 2'd0;
    localparam logic [1:0]  VERDICT_PASS   = 2'd1;
    localparam logic [1:0]  VERDICT_NOXL   = 2'd2;

    // icmpv6 types
    localparam logic [7:0]  I6_DST_UNREACH = 8'd1;
    localparam logic [7:0]  I6_PKT_TOO_BIG = 8'd2;
    localparam logic [7:0]  I6_TIME_EXCEED = 8'd3;
    localparam logic [7:0]  I6_PARAM_PROB  = 8'd4;
    localparam logic [7:0]  I6_ECHO_REQ    = 8'd128;
    localparam logic [7:0]  I6_ECHO_REP    = 8'd129;

    // icmpv4 types
    localparam logic [7:0]  I4_ECHO_REP    = 8'd0;
    localparam logic [7:0]  I4_DST_UNREACH = 8'd3;
    localparam logic [7:0]  I4_ECHO_REQ    = 8'd8;
    localparam logic [7:0]  I4_TIME_EXCEED = 8'd11;
    localparam logic [7:0]  I4_PARAM_PROB  = 8'd12;

    // input beat
    typedef struct packed {
        logic [15:0] ether_type;
        logic [7:0]  next_header;
        logic [7:0]  hops_left;
        logic [7:0]  traffic_class;
        logic [15:0] payload_length;
        logic [31:0] embedded_dst;
        logic [7:0]  msg6_type;
        logic [7:0]  msg6_code;
        logic [31:0] icmp6_rest;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic [1:0]  verdict;
        logic [15:0] ipv4_total_length;
        logic [7:0]  ipv4_tos;
        logic [7:0]  ipv4_ttl;
        logic [7:0]  ipv4_protocol;
        logic [31:0] ipv4_daddr;
        logic [15:0] ipv4_checksum;
        logic [7:0]  icmp_type;
        logic [7:0]  icmp_code;
        logic [31:0] icmp_rest;
        logic [15:0] icmp_checksum;
    } out_beat_t;

    // icmp mapper result
    typedef struct packed {
        logic        ok;
        logic [7:0]  itype;
        logic [7:0]  icode;
        logic [31:0] irest;
    } icmp_map_t;

    // ones complement fold of a 20 bit sum, inverted
    function automatic logic [15:0] fold16(input logic [19:0] s);
        logic [16:0] f;
        logic [16:0] g;
        f = {13'd0, s[19:16]} + {1'b0, s[15:0]};
        g = f + {16'd0, f[16]};
        return ~g[15:0];
    endfunction

endpackage

[rtl/n64xl_icmp_map.sv]
// ----------------------------------------------------------------------------
// n64xl_icmp_map
// Maps ICMPv6 type, code and bytes 4 to 7 onto their ICMPv4 equivalents,
// flagging messages that have no ICMPv4 translation.
// ----------------------------------------------------------------------------
module n64xl_icmp_map (
    input  logic [7:0]           t6,
    input  logic [7:0]           c6,
    input  logic [31:0]          r6,
    output n64xl_pkg::icmp_map_t map
);
    import n64xl_pkg::*;

    logic [31:0] mtu;
    logic [7:0]  ptr;
    logic        ptr_ok;

    // packet too big: mtu less the header growth
    assign mtu = r6 - {16'd0, HDR_LEN};

    // parameter problem pointer remap
    always_comb begin
        ptr    = 8'd0;
        ptr_ok = 1'b1;
        if (r6 <= 32'd1) begin
            ptr = r6[7:0];
        end else if (r6 == 32'd4 || r6 == 32'd5) begin
            ptr = 8'd2;
        end else if (r6 == 32'd6) begin
            ptr = 8'd9;
        end else if (r6 == 32'd7) begin
            ptr = 8'd8;
        end else if (r6 inside {[32'd8:32'd23]}) begin
            ptr = 8'd12;
        end else if (r6 inside {[32'd24:32'd39]}) begin
            ptr = 8'd16;
        end else begin
            ptr_ok = 1'b0;
        end
    end

    // type and code translation
    always_comb begin
        map.ok    = 1'b1;
        map.itype = 8'd0;
        map.icode = 8'd0;
        map.irest = r6;
        case (t6)
            I6_ECHO_REQ: begin
                map.itype = I4_ECHO_REQ;
            end
            I6_ECHO_REP: begin
                map.itype = I4_ECHO_REP;
            end
            I6_DST_UNREACH: begin
                map.itype = I4_DST_UNREACH;
                if (c6 inside {8'd0, 8'd2, 8'd3}) begin
                    map.icode = 8'd1;
                end else if (c6 == 8'd1) begin
                    map.icode = 8'd10;
                end else if (c6 == 8'd4) begin
                    map.icode = 8'd3;
                end else begin
                    map.ok = 1'b0;
                end
            end
            I6_PKT_TOO_BIG: begin
                map.itype = I4_DST_UNREACH;
                map.icode = 8'd4;
                map.irest = mtu;
                map.ok    = (mtu[31:16] == 16'd0);
            end
            I6_TIME_EXCEED: begin
                map.itype = I4_TIME_EXCEED;
                map.icode = c6;
            end
            I6_PARAM_PROB: begin
                if (c6 == 8'd0) begin
                    map.itype = I4_PARAM_PROB;
                    map.irest = {ptr, 24'd0};
                    map.ok    = ptr_ok;
                end else if (c6 == 8'd1) begin
                    map.itype = I4_DST_UNREACH;
                    map.icode = 8'd2;
                end else begin
                    map.ok = 1'b0;
                end
            end
            default: begin
                map.ok = 1'b0;
            end
        endcase
    end

endmodule

[rtl/nat64_ipv6_to_ipv4_translate_core.sv]
// ----------------------------------------------------------------------------
// nat64_ipv6_to_ipv4_translate_core
// Translates the header fields of one IPv6 frame per beat into IPv4 and
// ICMPv4 header fields, with both header checksums.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one frame's IPv6 header fields per beat.
//   m_valid/m_ready/m_data carry one translated result beat per input beat,
//   in order. cfg_valid/cfg_ready/cfg_data write the IPv4 source address;
//   cfg_ready is always high, and writes are expected only while idle.
//   Three register stages: an accepted beat moves from the stage 1 register
//   to stage 2 and then to stage 3, which drives m_valid. Stage 1 decodes
//   and maps ICMP, stage 2 sums the checksum words, stage 3 folds the sums
//   and masks unused fields into the output register.
//   Throughput is one beat per cycle while m_ready stays high; each stage holds one beat with its
//   own valid bit.
//   Reset clears all valid bits and loads the source address with its
//   default 0x0A000101.
//   When m_ready is low, beats hold in place; a stage still loads if the
//   stage ahead of it is empty, so bubbles close up and nothing is lost
//   or repeated.
// ----------------------------------------------------------------------------
module nat64_ipv6_to_ipv4_translate_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  n64xl_pkg::in_beat_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output n64xl_pkg::out_beat_t m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [31:0]          cfg_data
);
    import n64xl_pkg::*;

    typedef struct packed {
        logic [1:0]  verdict;
        logic        is_icmp;
        logic [15:0] tl;
        logic [7:0]  tos;
        logic [7:0]  ttl;
        logic [7:0]  proto;
        logic [31:0] dst;
        logic [19:0] sum_a;
        logic [7:0]  itype;
        logic [7:0]  icode;
        logic [31:0] irest;
    } st1_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic        is_icmp;
        logic [15:0] tl;
        logic [7:0]  tos;
        logic [7:0]  ttl;
        logic [7:0]  proto;
        logic [31:0] dst;
        logic [19:0] sum_ip;
        logic [19:0] sum_icmp;
        logic [7:0]  itype;
        logic [7:0]  icode;
        logic [31:0] irest;
    } st2_t;

    logic [31:0] src_reg;
    logic        v1_reg, v2_reg, v3_reg;
    st1_t        st1_reg, st1_next;
    st2_t        st2_reg, st2_next;
    out_beat_t   out_reg, out_next;
    logic        rdy1, rdy2, rdy3;
    icmp_map_t   imap;
    logic        is_v6, is_none, is_icmp;

    // stage advance: a stage loads when empty or when its beat moves on
    assign rdy3      = !v3_reg || m_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign s_ready   = rdy1;
    assign m_valid   = v3_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    // source address register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_reg <= V4_SRC_RESET;
        end else if (cfg_valid) begin
            src_reg <= cfg_data;
        end
    end

    n64xl_icmp_map u_icmp_map (
        .t6  (s_data.msg6_type),
        .c6  (s_data.msg6_code),
        .r6  (s_data.icmp6_rest),
        .map (imap)
    );

    // stage 1: classify, map icmp, total length, first checksum partial
    assign is_v6   = (s_data.ether_type == ETHERTYPE_V6);
    assign is_none = (s_data.next_header == NH_NONE);
    assign is_icmp = (s_data.next_header == NH_ICMP6);

    always_comb begin
        st1_next         = '0;
        st1_next.is_icmp = is_icmp;
        if (!is_v6 || !(is_none || is_icmp)) begin
            st1_next.verdict = VERDICT_PASS;
        end else if (is_icmp && !imap.ok) begin
            st1_next.verdict = VERDICT_NOXL;
        end else begin
            st1_next.verdict = VERDICT_XLATE;
        end
        st1_next.tl    = s_data.payload_length + HDR_LEN;
        st1_next.tos   = s_data.traffic_class;
        st1_next.ttl   = s_data.hops_left;
        st1_next.proto = is_icmp ? PROTO_ICMP : s_data.next_header;
        st1_next.dst   = s_data.embedded_dst;
        st1_next.sum_a = {4'd0, VER_IHL | {8'd0, s_data.traffic_class}}
                       + {4'd0, DF_FLAG}
                       + {4'd0, s_data.hops_left, st1_next.proto}
                       + {4'd0, src_reg[31:16]}
                       + {4'd0, src_reg[15:0]};
        st1_next.itype = imap.itype;
        st1_next.icode = imap.icode;
        st1_next.irest = imap.irest;
    end

    // stage 2: finish the ip sum, form the icmp sum
    always_comb begin
        st2_next.verdict  = st1_reg.verdict;
        st2_next.is_icmp  = st1_reg.is_icmp;
        st2_next.tl       = st1_reg.tl;
        st2_next.tos      = st1_reg.tos;
        st2_next.ttl      = st1_reg.ttl;
        st2_next.proto    = st1_reg.proto;
        st2_next.dst      = st1_reg.dst;
        st2_next.sum_ip   = st1_reg.sum_a
                          + {4'd0, st1_reg.tl}
                          + {4'd0, st1_reg.dst[31:16]}
                          + {4'd0, st1_reg.dst[15:0]};
        st2_next.sum_icmp = {4'd0, st1_reg.itype, st1_reg.icode}
                          + {4'd0, st1_reg.irest[31:16]}
                          + {4'd0, st1_reg.irest[15:0]};
        st2_next.itype    = st1_reg.itype;
        st2_next.icode    = st1_reg.icode;
        st2_next.irest    = st1_reg.irest;
    end

    // stage 3: fold sums, zero fields that do not apply
    always_comb begin
        out_next         = '0;
        out_next.verdict = st2_reg.verdict;
        if (st2_reg.verdict == VERDICT_XLATE) begin
            out_next.ipv4_total_length = st2_reg.tl;
            out_next.ipv4_tos          = st2_reg.tos;
            out_next.ipv4_ttl          = st2_reg.ttl;
            out_next.ipv4_protocol     = st2_reg.proto;
            out_next.ipv4_daddr        = st2_reg.dst;
            out_next.ipv4_checksum     = fold16(st2_reg.sum_ip);
            if (st2_reg.is_icmp) begin
                out_next.icmp_type     = st2_reg.itype;
                out_next.icmp_code     = st2_reg.icode;
                out_next.icmp_rest     = st2_reg.irest;
                out_next.icmp_checksum = fold16(st2_reg.sum_icmp);
            end
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // stage payload registers
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            st1_reg <= st1_next;
        end
        if (rdy2) begin
            st2_reg <= st2_next;
        end
        if (rdy3) begin
            out_reg <= out_next;
        end
    end

endmodule

[test/nat64_ipv6_to_ipv4_translate_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nat64_ipv6_to_ipv4_translate_core_tb
// Self-checking bench for the IPv6 to IPv4 header translation core. Frames
// go in through the s_ beat channel, and each one is predicted into the
// IPv4/ICMPv4 header it should become. Results on the m_ channel are checked
// in order, field by field. Directed frames cover pass-through, most ICMPv6
// mappings and their edge cases. Random traffic then runs under several source
// addresses, in some runs with bursty input or a stalling receiver.
// ----------------------------------------------------------------------------
module nat64_ipv6_to_ipv4_translate_core_tb;

    import n64xl_pkg::*;

    // icmpv6 destination unreachable codes
    localparam logic [7:0] U6_NO_ROUTE    = 8'd0;
    localparam logic [7:0] U6_ADMIN       = 8'd1;
    localparam logic [7:0] U6_BEYOND      = 8'd2;
    localparam logic [7:0] U6_ADDR        = 8'd3;
    localparam logic [7:0] U6_PORT        = 8'd4;
    localparam logic [7:0] U6_POLICY      = 8'd5;
    // icmpv6 parameter problem codes
    localparam logic [7:0] PP6_HDR_FIELD  = 8'd0;
    localparam logic [7:0] PP6_NEXT_HDR   = 8'd1;
    localparam logic [7:0] PP6_OPTION     = 8'd2;
    // icmpv4 destination unreachable codes
    localparam logic [7:0] U4_HOST        = 8'd1;
    localparam logic [7:0] U4_PROTO       = 8'd2;
    localparam logic [7:0] U4_PORT        = 8'd3;
    localparam logic [7:0] U4_FRAG_NEEDED = 8'd4;
    localparam logic [7:0] U4_HOST_ADMIN  = 8'd10;
    localparam logic [7:0] PP4_POINTER    = 8'd0;
    localparam logic [7:0] ECHO_CODE      = 8'd0;

    // receiver stall patterns
    localparam int STALL_NONE = 0;
    localparam int STALL_RAND = 1;
    localparam int STALL_LONG = 2;

    localparam int IDLE_LIMIT = 2000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_beat_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_beat_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    out_beat_t   v4_hdr_q[$];
    logic [31:0] src_addr_model = V4_SRC_RESET;
    int          err_cnt = 0;
    int          idle_cycles = 0;
    bit          gaps_on = 1'b0;
    int          burst_left = 0;
    int          stall_mode = STALL_NONE;
    int          stall_left = 0;

    nat64_ipv6_to_ipv4_translate_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // ones complement sum of 16 bit words, inverted
    function automatic logic [15:0] csum16(input logic [31:0] acc);
        logic [31:0] t;
        t = {16'd0, acc[31:16]} + {16'd0, acc[15:0]};
        t = t + {16'd0, t[31:16]};
        return ~t[15:0];
    endfunction

    // icmpv6 to icmpv4 type/code/rest mapping, returns 0 when untranslatable
    function automatic bit xlate_icmp(input logic [7:0] t6, input logic [7:0] c6,
                                      input logic [31:0] r6, output logic [7:0] t4,
                                      output logic [7:0] c4, output logic [31:0] r4);
        logic [31:0] mtu;
        logic [7:0]  ptr;
        t4 = '0;
        c4 = '0;
        r4 = r6;
        case (t6)
            I6_ECHO_REQ: begin
                t4 = I4_ECHO_REQ;
                c4 = ECHO_CODE;
                return 1'b1;
            end
            I6_ECHO_REP: begin
                t4 = I4_ECHO_REP;
                c4 = ECHO_CODE;
                return 1'b1;
            end
            I6_DST_UNREACH: begin
                t4 = I4_DST_UNREACH;
                case (c6)
                    U6_NO_ROUTE, U6_BEYOND, U6_ADDR: c4 = U4_HOST;
                    U6_ADMIN:                        c4 = U4_HOST_ADMIN;
                    U6_PORT:                         c4 = U4_PORT;
                    default:                         return 1'b0;
                endcase
                return 1'b1;
            end
            I6_PKT_TOO_BIG: begin
                t4 = I4_DST_UNREACH;
                c4 = U4_FRAG_NEEDED;
                // mtu shrinks by the header size difference, must fit 16 bits
                mtu = r6 - {16'd0, HDR_LEN};
                if (mtu > 32'h0000_FFFF) return 1'b0;
                r4 = mtu;
                return 1'b1;
            end
            I6_TIME_EXCEED: begin
                t4 = I4_TIME_EXCEED;
                c4 = c6;
                return 1'b1;
            end
            I6_PARAM_PROB: begin
                if (c6 == PP6_HDR_FIELD) begin
                    t4 = I4_PARAM_PROB;
                    c4 = PP4_POINTER;
                    // pointer into the ipv6 header moves to the ipv4 offset
                    if (r6 <= 32'd1)                      ptr = r6[7:0];
                    else if (r6 == 32'd4 || r6 == 32'd5) ptr = 8'd2;
                    else if (r6 == 32'd6)                ptr = 8'd9;
                    else if (r6 == 32'd7)                ptr = 8'd8;
                    else if (r6 >= 32'd8 && r6 <= 32'd23)  ptr = 8'd12;
                    else if (r6 >= 32'd24 && r6 <= 32'd39) ptr = 8'd16;
                    else return 1'b0;
                    r4 = {ptr, 24'd0};
                    return 1'b1;
                end
                if (c6 == PP6_NEXT_HDR) begin
                    t4 = I4_DST_UNREACH;
                    c4 = U4_PROTO;
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    // expected ipv4 header beat for one ipv6 frame
    function automatic out_beat_t xlate_header(input in_beat_t f, input logic [31:0] src);
        out_beat_t   r;
        logic [7:0]  it;
        logic [7:0]  ic;
        logic [31:0] ir;
        logic [7:0]  proto;
        logic [15:0] tl;
        logic [31:0] acc;
        r = '0;
        if (f.ether_type != ETHERTYPE_V6 ||
            (f.next_header != NH_NONE && f.next_header != NH_ICMP6)) begin
            r.verdict = VERDICT_PASS;
            return r;
        end
        proto = f.next_header;
        if (f.next_header == NH_ICMP6) begin
            if (!xlate_icmp(f.msg6_type, f.msg6_code, f.icmp6_rest, it, ic, ir)) begin
                r.verdict = VERDICT_NOXL;
                return r;
            end
            proto           = PROTO_ICMP;
            r.icmp_type     = it;
            r.icmp_code     = ic;
            r.icmp_rest     = ir;
            r.icmp_checksum = csum16({16'd0, it, ic} + {16'd0, ir[31:16]}
                                     + {16'd0, ir[15:0]});
        end
        tl  = f.payload_length + HDR_LEN;
        acc = {16'd0, VER_IHL | {8'd0, f.traffic_class}} + {16'd0, tl}
              + {16'd0, DF_FLAG} + {16'd0, f.hops_left, proto}
              + {16'd0, src[31:16]} + {16'd0, src[15:0]}
              + {16'd0, f.embedded_dst[31:16]} + {16'd0, f.embedded_dst[15:0]};
        r.verdict           = VERDICT_XLATE;
        r.ipv4_total_length = tl;
        r.ipv4_tos          = f.traffic_class;
        r.ipv4_ttl          = f.hops_left;
        r.ipv4_protocol     = proto;
        r.ipv4_daddr        = f.embedded_dst;
        r.ipv4_checksum     = csum16(acc);
        return r;
    endfunction

    // ipv6 frame with random header fields
    function automatic in_beat_t v6_frame(input logic [7:0] nh);
        in_beat_t f;
        f.ether_type     = ETHERTYPE_V6;
        f.next_header    = nh;
        f.hops_left      = 8'($urandom);
        f.traffic_class  = 8'($urandom);
        f.payload_length = 16'($urandom);
        f.embedded_dst   = $urandom;
        f.msg6_type      = 8'($urandom);
        f.msg6_code      = 8'($urandom);
        f.icmp6_rest     = $urandom;
        return f;
    endfunction

    function automatic in_beat_t icmp_frame(input logic [7:0] t6, input logic [7:0] c6,
                                            input logic [31:0] r6);
        in_beat_t f;
        f            = v6_frame(NH_ICMP6);
        f.msg6_type  = t6;
        f.msg6_code  = c6;
        f.icmp6_rest = r6;
        return f;
    endfunction

    // random frame, mostly well-formed icmpv6 with some noise
    function automatic in_beat_t rand_frame();
        in_beat_t f;
        int       pick;
        f    = v6_frame(NH_ICMP6);
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            f.ether_type = 16'($urandom);
        end else if (pick < 15) begin
            f.next_header = 8'($urandom);
        end else if (pick < 35) begin
            f.next_header = NH_NONE;
        end else begin
            case ($urandom_range(0, 13))
                0, 12:  f.msg6_type = I6_ECHO_REQ;
                1, 13:  f.msg6_type = I6_ECHO_REP;
                2: begin
                    f.msg6_type = I6_DST_UNREACH;
                    f.msg6_code = 8'($urandom_range(0, 5));
                end
                3:      f.msg6_type = I6_DST_UNREACH;
                4: begin
                    f.msg6_type  = I6_PKT_TOO_BIG;
                    f.icmp6_rest = $urandom_range(0, 32'h0001_0030);
                end
                5:      f.msg6_type = I6_PKT_TOO_BIG;
                6:      f.msg6_type = I6_TIME_EXCEED;
                7: begin
                    f.msg6_type  = I6_PARAM_PROB;
                    f.msg6_code  = PP6_HDR_FIELD;
                    f.icmp6_rest = $urandom_range(0, 45);
                end
                8: begin
                    f.msg6_type = I6_PARAM_PROB;
                    f.msg6_code = PP6_HDR_FIELD;
                end
                9: begin
                    f.msg6_type = I6_PARAM_PROB;
                    f.msg6_code = 8'($urandom_range(0, 3));
                end
                10: begin
                    f.msg6_type = I6_PARAM_PROB;
                    f.msg6_code = PP6_NEXT_HDR;
                end
                default: ;
            endcase
        end
        return f;
    endfunction

    // drive one frame and wait for it to be taken, then maybe idle
    task automatic send_frame(input in_beat_t f);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= f;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (gaps_on) begin
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 20);
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge aclk);
            end
        end
    endtask

    task automatic idle_sender();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // wait until every predicted header has come back
    task automatic wait_drained();
        while (v4_hdr_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // program the ipv4 source address while the core is idle
    task automatic write_source(input logic [31:0] addr);
        wait_drained();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= addr;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        src_addr_model = addr;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_pass_through();
        in_beat_t f;
        f            = v6_frame(NH_NONE);
        f.ether_type = 16'h0800;
        send_frame(f);
        f            = v6_frame(8'h06);
        send_frame(f);
        f            = v6_frame(NH_ICMP6);
        f.ether_type = 16'h0000;
        send_frame(f);
    endtask

    task automatic test_no_next_header();
        in_beat_t f;
        // all ones, payload length wraps past 16 bits
        f                = '1;
        f.ether_type     = ETHERTYPE_V6;
        f.next_header    = NH_NONE;
        send_frame(f);
        f                = '0;
        f.ether_type     = ETHERTYPE_V6;
        f.next_header    = NH_NONE;
        send_frame(f);
    endtask

    task automatic test_icmp_echo();
        send_frame(icmp_frame(I6_ECHO_REQ, 8'($urandom), 32'hFFFF_FFFF));
        send_frame(icmp_frame(I6_ECHO_REP, 8'($urandom), 32'h0000_0000));
    endtask

    task automatic test_dst_unreach();
        send_frame(icmp_frame(I6_DST_UNREACH, U6_NO_ROUTE, $urandom));
        send_frame(icmp_frame(I6_DST_UNREACH, U6_ADMIN, $urandom));
        send_frame(icmp_frame(I6_DST_UNREACH, U6_PORT, $urandom));
        send_frame(icmp_frame(I6_DST_UNREACH, U6_POLICY, $urandom));
    endtask

    // mtu at zero, at the 16 bit limit, just past it, and wrapping below zero
    task automatic test_packet_too_big();
        send_frame(icmp_frame(I6_PKT_TOO_BIG, 8'($urandom), 32'd20));
        send_frame(icmp_frame(I6_PKT_TOO_BIG, 8'($urandom), 32'h0001_0013));
        send_frame(icmp_frame(I6_PKT_TOO_BIG, 8'($urandom), 32'h0001_0014));
        send_frame(icmp_frame(I6_PKT_TOO_BIG, 8'($urandom), 32'd19));
    endtask

    task automatic test_time_exceeded();
        send_frame(icmp_frame(I6_TIME_EXCEED, 8'hFF, $urandom));
    endtask

    // pointer range edges, plus the other parameter problem codes
    task automatic test_param_problem();
        send_frame(icmp_frame(I6_PARAM_PROB, PP6_HDR_FIELD, 32'd0));
        send_frame(icmp_frame(I6_PARAM_PROB, PP6_HDR_FIELD, 32'd2));
        send_frame(icmp_frame(I6_PARAM_PROB, PP6_HDR_FIELD, 32'd6));
        send_frame(icmp_frame(I6_PARAM_PROB, PP6_HDR_FIELD, 32'd7));
        send_frame(icmp_frame(I6_PARAM_PROB, PP6_HDR_FIELD, 32'd23));
        send_frame(icmp_frame(I6_PARAM_PROB, PP6_HDR_FIELD, 32'd24));
        send_frame(icmp_frame(I6_PARAM_PROB, PP6_HDR_FIELD, 32'd39));
        send_frame(icmp_frame(I6_PARAM_PROB, PP6_HDR_FIELD, 32'd40));
        send_frame(icmp_frame(I6_PARAM_PROB, PP6_NEXT_HDR, $urandom));
        send_frame(icmp_frame(I6_PARAM_PROB, PP6_OPTION, $urandom));
    endtask

    task automatic test_unknown_icmp();
        send_frame(icmp_frame(8'd0, 8'($urandom), $urandom));
    endtask

    // random traffic under one source address and one idling pattern
    task automatic test_random_traffic(input logic [31:0] src, input int n_frames,
                                       input bit gaps, input int stall);
        write_source(src);
        gaps_on    = gaps;
        burst_left = 0;
        stall_mode = stall;
        repeat (n_frames) send_frame(rand_frame());
        idle_sender();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    // predict on every accepted input beat
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            v4_hdr_q.push_back(xlate_header(s_data, src_addr_model));
    end

    // compare every accepted result beat with the oldest prediction
    always @(posedge aclk) begin : check_results
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (v4_hdr_q.size() == 0) begin
                $error("result beat with nothing pending: %p", m_data);
                err_cnt++;
            end else begin
                want = v4_hdr_q.pop_front();
                check_field("verdict", 32'(want.verdict), 32'(m_data.verdict));
                check_field("ipv4_total_length", 32'(want.ipv4_total_length),
                            32'(m_data.ipv4_total_length));
                check_field("ipv4_tos", 32'(want.ipv4_tos), 32'(m_data.ipv4_tos));
                check_field("ipv4_ttl", 32'(want.ipv4_ttl), 32'(m_data.ipv4_ttl));
                check_field("ipv4_protocol", 32'(want.ipv4_protocol),
                            32'(m_data.ipv4_protocol));
                check_field("ipv4_daddr", want.ipv4_daddr, m_data.ipv4_daddr);
                check_field("ipv4_checksum", 32'(want.ipv4_checksum),
                            32'(m_data.ipv4_checksum));
                check_field("icmp_type", 32'(want.icmp_type), 32'(m_data.icmp_type));
                check_field("icmp_code", 32'(want.icmp_code), 32'(m_data.icmp_code));
                check_field("icmp_rest", want.icmp_rest, m_data.icmp_rest);
                check_field("icmp_checksum", 32'(want.icmp_checksum),
                            32'(m_data.icmp_checksum));
            end
        end
    end

    // receiver backpressure
    always @(negedge aclk) begin
        case (stall_mode)
            STALL_RAND: m_ready <= ($urandom_range(0, 99) >= 30);
            STALL_LONG: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else if ($urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(1, 12);
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
            default: m_ready <= 1'b1;
        endcase
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("nat64_ipv6_to_ipv4_translate_core_tb: FAIL");
                $finish;
            end
        end
    end

    // test sequence
    initial begin : run
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed frames at the reset source address
        test_pass_through();
        test_no_next_header();
        test_icmp_echo();
        test_dst_unreach();
        test_packet_too_big();
        test_time_exceeded();
        test_param_problem();
        test_unknown_icmp();
        idle_sender();

        test_random_traffic(32'h0000_0000, 275, 1'b0, STALL_NONE);
        test_random_traffic(32'hFFFF_FFFF, 275, 1'b1, STALL_RAND);
        test_random_traffic($urandom, 275, 1'b1, STALL_LONG);
        test_random_traffic(V4_SRC_RESET, 275, 1'b0, STALL_LONG);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (err_cnt == 0)
            $display("nat64_ipv6_to_ipv4_translate_core_tb: PASS");
        else
            $display("nat64_ipv6_to_ipv4_translate_core_tb: FAIL");
        $finish;
    end

endmodule
